// File: rtl/tcs_pkg.sv
package tcs_pkg;

  // Default widths
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  // Q16 unity
  localparam logic [16:0] Q_ONE = 17'h10000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FADE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FADE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MODE     = 3'd5;

  // Route modes
  localparam logic [2:0] MODE_GATE  = 3'd0;
  localparam logic [2:0] MODE_IN1   = 3'd1;
  localparam logic [2:0] MODE_IN2   = 3'd2;
  localparam logic [2:0] MODE_XFADE = 3'd3;
  localparam logic [2:0] MODE_OFF   = 3'd4;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/threshold_crossfade_switch_core.sv
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in       in         in_valid_i  / in_ready_o  control_sample_i, threshold_cv_i,
//                                               fade_offset_i, in_one_i, in_two_i
// out      out        out_valid_o / out_ready_i out_sample_o, level_one_o, level_two_o
//
// One input transfer passes the threshold multiply, threshold, compare, select and
// done steps; while a fade runs, the divide step and mix steps A to C precede done.
// The bit-serial progress divider makes COUNT_BITS + 16 quotient bits, one per cycle.
// One signed multiplier is shared by the threshold gain and the two mix terms.
// in_ready_o is high only while the sequencer is idle. The result sits in an
// output register, so the next sample is taken while it waits; a finished sample
// waits in the last step until the output register frees up.
// Reset is asynchronous, active low; cfg_ready_o is always high.
module threshold_crossfade_switch_core #(
  parameter int unsigned SAMPLE_BITS = tcs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = tcs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input samples
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       control_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       threshold_cv_i,
  input  logic signed [20:0]                  fade_offset_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_one_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_two_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_o,
  output logic [16:0]                         level_one_o,
  output logic [16:0]                         level_two_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + 18;
  localparam int unsigned QUO_W  = COUNT_BITS + 16;

  localparam logic signed [SAMPLE_BITS-1:0] FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W:0] THR_HI =
    signed'((PROD_W+1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
  localparam logic signed [PROD_W:0] THR_LO = -THR_HI;
  localparam logic [32:0] COUNT_MAX_W = (33'd1 << COUNT_BITS) - 33'd1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_THR_MUL = 4'd1;
  localparam logic [3:0] S_THR     = 4'd2;
  localparam logic [3:0] S_CMP     = 4'd3;
  localparam logic [3:0] S_SEL     = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_MIX_A   = 4'd6;
  localparam logic [3:0] S_MIX_B   = 4'd7;
  localparam logic [3:0] S_MIX_C   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic signed [15:0] thr_base_q;
  logic signed [9:0]  thr_gain_q;
  logic [19:0]        fade_base_q;
  logic [9:0]         min_fade_q;
  logic [19:0]        max_fade_q;
  logic [2:0]         route_mode_q;

  // latched sample
  logic signed [SAMPLE_BITS-1:0] ctrl_q, cv_q, a_q, b_q;
  logic signed [20:0]            offs_q;

  // switch / fade state
  logic                  switch_on_q, switch_on_d;
  logic                  fade_active_q, fade_active_d;
  logic [COUNT_BITS-1:0] fade_count_q, fade_count_d;
  logic [COUNT_BITS-1:0] fade_length_q, fade_length_d;
  logic [16:0]           fade_start_q, fade_start_d;
  logic [16:0]           fade_progress_q, fade_progress_d;
  logic signed [SAMPLE_BITS-1:0] held_out_q, held_out_d;
  logic [16:0]           held_l1_q, held_l1_d;
  logic [16:0]           held_l2_q, held_l2_d;

  // datapath
  logic signed [SAMPLE_BITS-1:0] thr_q, thr_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [PROD_W:0]        acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [17:0]            mul_b;
  logic signed [PROD_W:0]        prod_ext;
  logic signed [PROD_W:0]        thr_sum;
  logic signed [PROD_W:0]        mix_sum;
  logic signed [21:0]            raw_len;
  logic [20:0]                   len_c;
  logic [32:0]                   len_w;
  logic                          now_on;
  logic signed [SAMPLE_BITS-1:0] new_val, old_val;
  logic [QUO_W:0]                prog_sum;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic [16:0]                   out_l1_q, out_l2_q;
  logic                          out_load;

  // divider
  logic                 div_start;
  logic [QUO_W-1:0]     div_quo;
  tcs_pkg::div_status_t div_st;

  function automatic logic signed [SAMPLE_BITS-1:0] steady_out(
    input logic [2:0]                    mode,
    input logic                          on,
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [SAMPLE_BITS-1:0] r;
    case (mode)
      tcs_pkg::MODE_GATE: r = on ? FULL : '0;
      tcs_pkg::MODE_IN1:  r = on ? '0 : a;
      tcs_pkg::MODE_IN2:  r = on ? b : '0;
      default:            r = on ? b : a;
    endcase
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Shared multiplier: threshold gain, then the two crossfade terms.
  always_comb begin
    case (state_q)
      S_MIX_A: begin
        mul_a = new_val;
        mul_b = {1'b0, fade_progress_q};
      end
      S_MIX_B: begin
        mul_a = old_val;
        mul_b = {1'b0, tcs_pkg::Q_ONE - fade_progress_q};
      end
      default: begin
        mul_a = cv_q;
        mul_b = {{8{thr_gain_q[9]}}, thr_gain_q};
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {prod_q[PROD_W-1], prod_q};
  assign thr_sum  = signed'({{(PROD_W+1-16){thr_base_q[15]}}, thr_base_q}) +
                    (prod_ext >>> 8);
  assign mix_sum  = acc_q + prod_ext;

  always_comb begin
    if (thr_sum > THR_HI) begin
      thr_d = FULL;
    end else if (thr_sum < THR_LO) begin
      thr_d = -FULL;
    end else begin
      thr_d = thr_sum[SAMPLE_BITS-1:0];
    end
  end

  // Fade length: base plus offset, clamped to 0..max and to the counter range.
  assign raw_len = signed'({2'b00, fade_base_q}) + signed'({offs_q[20], offs_q});
  always_comb begin
    if (raw_len[21]) begin
      len_c = '0;
    end else if (raw_len[20:0] > {1'b0, max_fade_q}) begin
      len_c = {1'b0, max_fade_q};
    end else begin
      len_c = raw_len[20:0];
    end
    len_w = ({12'b0, len_c} > COUNT_MAX_W) ? COUNT_MAX_W : {12'b0, len_c};
  end

  assign now_on   = (ctrl_q >= thr_q);
  assign new_val  = steady_out(route_mode_q, switch_on_q, a_q, b_q);
  assign old_val  = steady_out(route_mode_q, !switch_on_q, a_q, b_q);
  assign prog_sum = {1'b0, div_quo} + {{COUNT_BITS{1'b0}}, fade_start_q};
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign div_start = (state_q == S_SEL) && (route_mode_q < tcs_pkg::MODE_OFF) &&
                     fade_active_q && (fade_length_q != '0) && (fade_count_q != '1);

  tcs_div #(
    .DVD_W (QUO_W),
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({fade_count_q, 16'b0}),
    .divisor_i  (fade_length_q),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  // Sequencer
  always_comb begin
    state_d         = state_q;
    switch_on_d     = switch_on_q;
    fade_active_d   = fade_active_q;
    fade_count_d    = fade_count_q;
    fade_length_d   = fade_length_q;
    fade_start_d    = fade_start_q;
    fade_progress_d = fade_progress_q;
    held_out_d      = held_out_q;
    held_l1_d       = held_l1_q;
    held_l2_d       = held_l2_q;
    acc_d           = acc_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_THR_MUL;
        end
      end
      S_THR_MUL: state_d = S_THR;
      S_THR:     state_d = S_CMP;
      S_CMP: begin
        // crossing: toggle, take new length, maybe (re)start the fade
        if (now_on != switch_on_q) begin
          switch_on_d   = now_on;
          fade_length_d = len_w[COUNT_BITS-1:0];
          if (raw_len > signed'({12'b0, min_fade_q})) begin
            if (fade_active_q) begin
              fade_start_d = tcs_pkg::Q_ONE - fade_progress_q;
            end else begin
              fade_active_d = 1'b1;
              fade_start_d  = '0;
            end
            fade_count_d = '0;
          end
        end
        state_d = S_SEL;
      end
      S_SEL: begin
        if (route_mode_q >= tcs_pkg::MODE_OFF) begin
          // off: zero output, fade frozen
          held_out_d = '0;
          held_l1_d  = '0;
          held_l2_d  = '0;
          state_d    = S_DONE;
        end else if (!fade_active_q) begin
          held_out_d = new_val;
          if (route_mode_q == tcs_pkg::MODE_GATE) begin
            held_l1_d = '0;
            held_l2_d = '0;
          end else begin
            held_l1_d = switch_on_q ? 17'd0 : tcs_pkg::Q_ONE;
            held_l2_d = switch_on_q ? tcs_pkg::Q_ONE : 17'd0;
          end
          state_d = S_DONE;
        end else if (div_start) begin
          state_d = S_DIV;
        end else begin
          // zero length or saturated count: end, repeat last result
          fade_active_d   = 1'b0;
          fade_count_d    = '0;
          fade_start_d    = '0;
          fade_progress_d = '0;
          state_d         = S_DONE;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (prog_sum > (QUO_W+1)'(tcs_pkg::Q_ONE)) begin
            fade_active_d   = 1'b0;
            fade_count_d    = '0;
            fade_start_d    = '0;
            fade_progress_d = '0;
            state_d         = S_DONE;
          end else begin
            fade_progress_d = prog_sum[16:0];
            state_d         = S_MIX_A;
          end
        end
      end
      S_MIX_A: state_d = S_MIX_B;
      S_MIX_B: begin
        acc_d   = prod_ext + (PROD_W+1)'(32768);
        state_d = S_MIX_C;
      end
      S_MIX_C: begin
        held_out_d = mix_sum[SAMPLE_BITS+15:16];
        if (route_mode_q == tcs_pkg::MODE_GATE) begin
          held_l1_d = '0;
          held_l2_d = '0;
        end else if (switch_on_q) begin
          held_l1_d = tcs_pkg::Q_ONE - fade_progress_q;
          held_l2_d = fade_progress_q;
        end else begin
          held_l1_d = fade_progress_q;
          held_l2_d = tcs_pkg::Q_ONE - fade_progress_q;
        end
        fade_count_d = fade_count_q + COUNT_BITS'(1);
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      thr_base_q      <= 16'sd3277;
      thr_gain_q      <= '0;
      fade_base_q     <= 20'd48;
      min_fade_q      <= 10'd49;
      max_fade_q      <= 20'd480000;
      route_mode_q    <= tcs_pkg::MODE_OFF;
      switch_on_q     <= 1'b0;
      fade_active_q   <= 1'b0;
      fade_count_q    <= '0;
      fade_length_q   <= '0;
      fade_start_q    <= '0;
      fade_progress_q <= '0;
      held_out_q      <= '0;
      held_l1_q       <= '0;
      held_l2_q       <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      switch_on_q     <= switch_on_d;
      fade_active_q   <= fade_active_d;
      fade_count_q    <= fade_count_d;
      fade_length_q   <= fade_length_d;
      fade_start_q    <= fade_start_d;
      fade_progress_q <= fade_progress_d;
      held_out_q      <= held_out_d;
      held_l1_q       <= held_l1_d;
      held_l2_q       <= held_l2_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tcs_pkg::REG_THRESHOLD_BASE: thr_base_q   <= cfg_data_i[15:0];
          tcs_pkg::REG_THRESHOLD_GAIN: thr_gain_q   <= cfg_data_i[9:0];
          tcs_pkg::REG_FADE_BASE:      fade_base_q  <= cfg_data_i[19:0];
          tcs_pkg::REG_MIN_FADE:       min_fade_q   <= cfg_data_i[9:0];
          tcs_pkg::REG_MAX_FADE:       max_fade_q   <= cfg_data_i[19:0];
          tcs_pkg::REG_ROUTE_MODE:     route_mode_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctrl_q <= control_sample_i;
      cv_q   <= threshold_cv_i;
      offs_q <= fade_offset_i;
      a_q    <= in_one_i;
      b_q    <= in_two_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (state_q == S_THR) begin
      thr_q <= thr_d;
    end
    if (out_load) begin
      out_sample_q <= held_out_q;
      out_l1_q     <= held_l1_q;
      out_l2_q     <= held_l2_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign level_one_o  = out_l1_q;
  assign level_two_o  = out_l2_q;

  // Assertions
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIV))
    else $error("divider busy outside the divide step");

  a_progress_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fade_progress_q <= tcs_pkg::Q_ONE)
    else $error("fade progress above unity");

  a_idle_fade_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fade_active_q |-> (fade_count_q == '0 && fade_start_q == '0 &&
                        fade_progress_q == '0))
    else $error("fade state left over after fade end");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && out_sample_o == $past(held_out_q)))
    else $error("result not moved to the output register");

endmodule

// File: rtl/tcs_div.sv
// Restoring divider, one quotient bit per cycle.
module tcs_div #(
  parameter int unsigned DVD_W = tcs_pkg::COUNT_BITS_DEF + 16,
  parameter int unsigned DVS_W = tcs_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [DVS_W-1:0]           divisor_i,
  output logic [DVD_W-1:0]           quotient_o,
  output tcs_pkg::div_status_t       status_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DVS_W+1]) begin
        rem_d = diff[DVS_W:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: bench/threshold_crossfade_switch_core_tb.sv
`timescale 1ns / 1ps

module threshold_crossfade_switch_core_tb;
  import tcs_pkg::*;

  // Route codes past MODE_OFF are undefined and behave like off
  localparam logic [2:0] MODE_UNDEF  = 3'd7;

  localparam longint FULL_SCALE   = 32767;
  localparam longint COUNT_MAX    = (64'd1 << 20) - 1;
  localparam longint Q16          = 65536;
  localparam int     LIMIT_CYCLES = 1000000;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 183;
  localparam int     HOLD_OFF     = 400;

  typedef struct packed {
    logic signed [15:0] ctrl;
    logic signed [15:0] cv;
    logic signed [20:0] offs;
    logic signed [15:0] one;
    logic signed [15:0] two;
  } audio_item_t;

  typedef struct packed {
    logic signed [15:0] smp;
    logic [16:0]        lvl1;
    logic [16:0]        lvl2;
  } switch_out_t;

  // One line of the directed script: a register write or a sample, the
  // latter optionally with a hand-written expected output.
  typedef struct packed {
    bit          is_reg;
    logic [2:0]  idx;
    logic [19:0] data;
    audio_item_t it;
    bit          known;
    switch_out_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic                in_valid_i;
  logic                in_ready_o;
  logic signed [15:0]  control_sample_i;
  logic signed [15:0]  threshold_cv_i;
  logic signed [20:0]  fade_offset_i;
  logic signed [15:0]  in_one_i;
  logic signed [15:0]  in_two_i;

  logic                out_valid_o;
  logic                out_ready_i;
  logic signed [15:0]  out_sample_o;
  logic [16:0]         level_one_o;
  logic [16:0]         level_two_o;

  threshold_crossfade_switch_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .control_sample_i (control_sample_i),
    .threshold_cv_i   (threshold_cv_i),
    .fade_offset_i    (fade_offset_i),
    .in_one_i         (in_one_i),
    .in_two_i         (in_two_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_sample_o     (out_sample_o),
    .level_one_o      (level_one_o),
    .level_two_o      (level_two_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copy and switch/fade state, reset values as the block
  // ---------------------------------------------------------------------------
  logic signed [15:0] r_base  = 16'sd3277;
  logic signed [9:0]  r_gain  = 10'sd0;
  logic [19:0]        r_fbase = 20'd48;
  logic [9:0]         r_min   = 10'd49;
  logic [19:0]        r_max   = 20'd480000;
  logic [2:0]         r_mode  = MODE_OFF;

  bit     sw_on   = 1'b0;
  bit     fading  = 1'b0;
  longint fcount  = 0;
  longint flen    = 0;
  longint fstart  = 0;
  longint fprog   = 0;
  switch_out_t held = '0;

  int fade_starts = 0;
  int fade_ends   = 0;

  // Base plus Q8-scaled CV, pinned to +-full scale
  function automatic longint threshold_for(logic signed [15:0] cv);
    longint t;
    t = longint'(r_base) + ((longint'(cv) * longint'(r_gain)) >>> 8);
    if (t > FULL_SCALE) t = FULL_SCALE;
    if (t < -FULL_SCALE) t = -FULL_SCALE;
    return t;
  endfunction

  // Resting output and lamp levels for one switch position
  function automatic void settle(input logic [2:0] mode, input bit on,
                                 input longint a, input longint b,
                                 output longint o, output longint l1,
                                 output longint l2);
    case (mode)
      MODE_GATE: o = on ? FULL_SCALE : 0;
      MODE_IN1:  o = on ? 0 : a;
      MODE_IN2:  o = on ? b : 0;
      default:   o = on ? b : a;
    endcase
    l1 = (mode == MODE_GATE || on) ? 0 : Q16;
    l2 = (mode != MODE_GATE && on) ? Q16 : 0;
  endfunction

  // Q16 linear mix, rounded half up
  function automatic longint blend(longint nv, longint ov, longint p);
    return (nv * p + ov * (Q16 - p) + 32768) >>> 16;
  endfunction

  // Steps the switch by one sample and returns the output it must produce
  function automatic switch_out_t advance_switch(audio_item_t it);
    longint raw, len, prog, o, l1, l2, no, nl1, nl2, oo, ol1, ol2;
    bit now, ended, hold;
    o = 0; l1 = 0; l2 = 0; prog = 0; ended = 1'b0; hold = 1'b0;
    now = longint'(it.ctrl) >= threshold_for(it.cv);
    if (now != sw_on) begin
      raw = longint'(r_fbase) + longint'(it.offs);
      len = raw;
      sw_on = now;
      if (len < 0) len = 0;
      if (len > longint'(r_max)) len = longint'(r_max);
      if (len > COUNT_MAX) len = COUNT_MAX;
      // length is refreshed even when the crossing is too short to fade
      flen = len;
      if (raw > longint'(r_min)) begin
        if (fading) begin
          fstart = Q16 - fprog;
        end else begin
          fading = 1'b1;
          fstart = 0;
          fade_starts++;
        end
        fcount = 0;
      end
    end
    // off and undefined modes freeze a running fade
    if (r_mode <= MODE_XFADE) begin
      if (fading) begin
        if (flen == 0 || fcount >= COUNT_MAX) begin
          ended = 1'b1;
        end else begin
          prog  = fstart + (fcount << 16) / flen;
          ended = prog > Q16;
        end
        if (ended) begin
          fading = 1'b0;
          fcount = 0;
          fstart = 0;
          fprog  = 0;
          hold   = 1'b1;
          fade_ends++;
        end else begin
          fprog = prog;
          settle(r_mode, sw_on, it.one, it.two, no, nl1, nl2);
          settle(r_mode, !sw_on, it.one, it.two, oo, ol1, ol2);
          o  = blend(no, oo, prog);
          l1 = blend(nl1, ol1, prog);
          l2 = blend(nl2, ol2, prog);
          fcount++;
        end
      end else begin
        settle(r_mode, sw_on, it.one, it.two, o, l1, l2);
      end
    end
    // the sample a fade ends on repeats the previous output
    if (!hold) held = '{o[15:0], l1[16:0], l2[16:0]};
    return held;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  switch_out_t owed_outputs[$];
  bit          drv_known;
  switch_out_t drv_want;
  int errors        = 0;
  int n_samples     = 0;
  int n_outputs     = 0;
  int n_writes      = 0;
  int cycles        = 0;

  task automatic flag_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  // Everything is sampled at the rising edge; the bench drives on the falling
  // edge, so the values seen here are the ones that took part in the transfer.
  always @(posedge clk_i) begin
    switch_out_t got, want, pred;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        n_writes++;
        case (cfg_index_i)
          REG_THRESHOLD_BASE: r_base  = cfg_data_i[15:0];
          REG_THRESHOLD_GAIN: r_gain  = cfg_data_i[9:0];
          REG_FADE_BASE:      r_fbase = cfg_data_i;
          REG_MIN_FADE:       r_min   = cfg_data_i[9:0];
          REG_MAX_FADE:       r_max   = cfg_data_i;
          REG_ROUTE_MODE:     r_mode  = cfg_data_i[2:0];
          default: ;
        endcase
      end
      // check the output side first so a result can never match its own sample
      if (out_valid_o && out_ready_i) begin
        got = '{out_sample_o, level_one_o, level_two_o};
        if (owed_outputs.size() == 0) begin
          flag_mismatch($sformatf("output %0d/%0d/%0d with nothing owed",
                                  got.smp, got.lvl1, got.lvl2));
        end else begin
          want = owed_outputs.pop_front();
          n_outputs++;
          if (got.smp !== want.smp)
            flag_mismatch($sformatf("output #%0d out_sample %0d, want %0d",
                                    n_outputs, got.smp, want.smp));
          if (got.lvl1 !== want.lvl1)
            flag_mismatch($sformatf("output #%0d level_one %0d, want %0d",
                                    n_outputs, got.lvl1, want.lvl1));
          if (got.lvl2 !== want.lvl2)
            flag_mismatch($sformatf("output #%0d level_two %0d, want %0d",
                                    n_outputs, got.lvl2, want.lvl2));
        end
      end
      if (in_valid_i && in_ready_o) begin
        // predictor always runs so its state tracks the block; hand-typed
        // rows override the value that gets checked
        pred = advance_switch('{control_sample_i, threshold_cv_i, fade_offset_i,
                                in_one_i, in_two_i});
        owed_outputs.push_back(drv_known ? drv_want : pred);
        n_samples++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d outputs still owed", cycles,
               owed_outputs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off counted down here
  // ---------------------------------------------------------------------------
  int src_idle   = 0;
  int sink_stall = 0;
  int hold_left  = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: entered and left on a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(audio_item_t it, bit known, switch_out_t want);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    control_sample_i <= it.ctrl;
    threshold_cv_i   <= it.cv;
    fade_offset_i    <= it.offs;
    in_one_i         <= it.one;
    in_two_i         <= it.two;
    drv_known        <= known;
    drv_want         <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Registers change only with nothing in flight: drain, settle, then write
  task automatic write_reg(logic [2:0] idx, logic [19:0] data);
    in_valid_i <= 1'b0;
    while (owed_outputs.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random sample that sits on the requested side of the live threshold;
  // some land right on the edge, a few are pure noise.
  function automatic audio_item_t make_item(bit on);
    audio_item_t it;
    longint thr;
    it.cv   = 16'($urandom);
    it.one  = 16'($urandom);
    it.two  = 16'($urandom);
    it.offs = ($urandom_range(6) == 0) ? 21'($urandom)
                                       : 21'(int'($urandom_range(40)) - 8);
    thr = threshold_for(it.cv);
    if ($urandom_range(9) == 0)
      it.ctrl = 16'($urandom);
    else if ($urandom_range(11) == 0)
      it.ctrl = on ? 16'(thr) : 16'(thr - 1);
    else if (on)
      it.ctrl = 16'(thr + longint'($urandom_range(32'(FULL_SCALE - thr))));
    else
      it.ctrl = 16'(-32768 + longint'($urandom_range(32'(thr + FULL_SCALE))));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------
  stim_row_t script[$];

  task automatic add_reg(logic [2:0] idx, int data);
    stim_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = 20'(data);
    script.push_back(r);
  endtask

  task automatic add_item(int ctrl, int cv, int offs, int a, int b,
                          bit known = 1'b0, int o = 0, int l1 = 0, int l2 = 0);
    stim_row_t r;
    r       = '0;
    r.it    = '{16'(ctrl), 16'(cv), 21'(offs), 16'(a), 16'(b)};
    r.known = known;
    r.want  = '{16'(o), 17'(l1), 17'(l2)};
    script.push_back(r);
  endtask

  task automatic build_script();
    // Reset state: off mode gives silence whatever the inputs
    add_item(-32768, 0, 0, 1234, -1234, 1, 0, 0, 0);
    // Gate: low then high; base length 48 is under the minimum, no fade
    add_reg(REG_ROUTE_MODE, MODE_GATE);
    add_item(-32768, 0, 0, 0, 0, 1, 0, 0, 0);
    add_item(32767, 0, 0, 0, 0, 1, 32767, 0, 0);
    // Input one only, both switch positions
    add_reg(REG_ROUTE_MODE, MODE_IN1);
    add_item(32767, 0, 0, 5, 7, 1, 0, 0, 65536);
    add_item(-32768, 0, 0, -32768, 7, 1, -32768, 65536, 0);
    // Input two only, switch off
    add_reg(REG_ROUTE_MODE, MODE_IN2);
    add_item(-32768, 0, 0, 3, 32767, 1, 0, 65536, 0);
    // Crossfade mode, switch on, still too short to fade
    add_reg(REG_ROUTE_MODE, MODE_XFADE);
    add_item(32767, 0, 0, 32767, -32768, 1, -32768, 0, 65536);
    // Lengths now come straight from the offset
    add_reg(REG_FADE_BASE, 0);
    add_reg(REG_MIN_FADE, 0);
    add_item(-32768, 0, 4, 20000, -20000);          // fade over 4 samples
    add_item(-32768, 0, 0, 20000, -20000);
    add_item(32767, 0, 8, 20000, -20000);           // crossing mid-fade: mirror
    add_item(32767, 0, 0, -7, 32767);
    add_item(32767, 0, 0, -7, 32767);
    add_item(32767, 0, 0, -7, 32767);               // overrun: previous held
    add_item(-32768, 0, -1048576, 100, 200);        // negative length, no fade
    add_item(32767, 0, 1048575, 100, 200);          // clamped to max length
    add_item(32767, 0, 0, 100, 200);
    add_item(-32768, 0, -1, 100, 200);              // short crossing zeroes length
    // Zero max length and an undefined route: fade starts but is frozen
    add_reg(REG_MAX_FADE, 0);
    add_reg(REG_ROUTE_MODE, MODE_UNDEF);
    add_item(32767, 0, 5, 999, -999);
    add_reg(REG_ROUTE_MODE, MODE_GATE);
    add_item(-32768, 0, 0, 999, -999);              // zero length ends it at once
    // Extreme registers: threshold clamps high, full-size fade
    add_reg(REG_THRESHOLD_BASE, 32767);
    add_reg(REG_THRESHOLD_GAIN, 256);
    add_reg(REG_MAX_FADE, 1048575);
    add_reg(REG_FADE_BASE, 1048575);
    add_reg(REG_MIN_FADE, 1023);
    add_item(32767, 32767, 0, 0, 0);
    // Out-of-range patterns: base 0x8000, gain -512; threshold clamps low
    add_reg(REG_THRESHOLD_BASE, 'h08000);
    add_reg(REG_THRESHOLD_GAIN, 'h00200);
    add_item(-32768, 32767, 0, -32768, 32767);      // crossing mid-fade again
    add_item(-32767, 0, -1048576, 32767, -32768);   // equal to threshold
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  v;
    bit  on_side;
    int  toggle_pct;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    control_sample_i = '0;
    threshold_cv_i   = '0;
    fade_offset_i    = '0;
    in_one_i         = '0;
    in_two_i         = '0;
    out_ready_i      = 1'b0;
    drv_known        = 1'b0;
    drv_want         = '0;
    on_side          = 1'b0;

    build_script();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_reg)
        write_reg(script[i].idx, script[i].data);
      else
        send_item(script[i].it, script[i].known, script[i].want);
    end

    // Random setups, cycling through four idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 49; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 49; end
        default: begin src_idle = 37; sink_stall = 37; end
      endcase

      v = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 32767 : -32767)
                                   : int'($urandom_range(12000)) - 6000;
      write_reg(REG_THRESHOLD_BASE, 20'(v));
      v = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 256 : -256)
                                   : int'($urandom_range(512)) - 256;
      write_reg(REG_THRESHOLD_GAIN, 20'(v));
      v = ($urandom_range(7) == 0) ? 1048575 : int'($urandom_range(24));
      write_reg(REG_FADE_BASE, 20'(v));
      v = ($urandom_range(7) == 0) ? 1023 : int'($urandom_range(12));
      write_reg(REG_MIN_FADE, 20'(v));
      v = ($urandom_range(7) == 0) ? 1048575 : int'($urandom_range(1, 48));
      write_reg(REG_MAX_FADE, 20'(v));
      v = ($urandom_range(7) == 0) ? int'($urandom_range(MODE_OFF, MODE_UNDEF))
                                   : int'($urandom_range(MODE_GATE, MODE_XFADE));
      write_reg(REG_ROUTE_MODE, 20'(v));

      // mostly steady control with crossings now and then
      toggle_pct = $urandom_range(3, 30);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // back-pressure: output held off while samples keep coming
        if (p == 0 && k == 40) hold_left = HOLD_OFF;
        if ($urandom_range(99) < toggle_pct) on_side = !on_side;
        send_item(make_item(on_side), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (owed_outputs.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (owed_outputs.size() != 0)
      flag_mismatch($sformatf("%0d outputs never arrived", owed_outputs.size()));

    $display("Run covered %0d samples, %0d outputs checked, %0d register writes",
             n_samples, n_outputs, n_writes);
    $display("All route codes, clamped thresholds; %0d fades started, %0d ended",
             fade_starts, fade_ends);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tcs_pkg.sv
rtl/tcs_div.sv
rtl/threshold_crossfade_switch_core.sv
bench/threshold_crossfade_switch_core_tb.sv
